[hw/rtl/tpsp_pkg.sv]
// Shared types, constants and helper functions of the tagged pair stream parser.
package tpsp_pkg;

  localparam int BYTE_W    = 8;
  localparam int DATA_W    = 64;
  localparam int KIND_W    = 2;
  localparam int RKIND_W   = 3;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_DATA_W = 136;

  typedef enum logic [2:0] {
    PH_MAGIC     = 3'd0,
    PH_VERSION   = 3'd1,
    PH_KEY_TAG   = 3'd2,
    PH_KEY_BYTES = 3'd3,
    PH_VAL_TAG   = 3'd4,
    PH_VAL_BYTES = 3'd5,
    PH_ERROR     = 3'd6
  } phase_t;

  typedef enum logic [RKIND_W-1:0] {
    RK_PAIR        = 3'd0,
    RK_END         = 3'd1,
    RK_BAD_MAGIC   = 3'd2,
    RK_BAD_VERSION = 3'd3,
    RK_BAD_TAG     = 3'd4,
    RK_TRUNCATED   = 3'd5
  } result_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODE_U8  = 3'd0,
    CFG_CODE_U16 = 3'd1,
    CFG_CODE_U32 = 3'd2,
    CFG_CODE_U64 = 3'd3,
    CFG_VERSION  = 3'd4
  } cfg_index_t;

  // Header magic, first byte first: 'K', 'V', 'S', NUL.
  function automatic logic [BYTE_W-1:0] magic_byte(input logic [1:0] idx);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      2'd0:    b = 8'h4B;
      2'd1:    b = 8'h56;
      2'd2:    b = 8'h53;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Number of data bytes behind a tag of the given width code.
  function automatic logic [CNT_W-1:0] kind_len(input logic [KIND_W-1:0] kind);
    return CNT_W'(1) << kind;
  endfunction

endpackage

[hw/rtl/tagged_pair_stream_parser_core.sv]
// Top level of the tagged pair stream parser: header check, pair assembly, result register.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  in_     | in        | tvalid / tready   | tdata: stream byte, tlast: end of stream
//  out_    | out       | tvalid / tready   | tuser: result kind, tdata: key and value
//  cfg_    | in        | valid / ready     | index (3 bits), data (8 bits); always ready
//
// One item per cycle while the output does not stall: an accepted item sits in the input register,
// its parse step runs between that register and the result register.
// An item that gives a result passes the input register and then the result register, which drives out_tvalid.
// A held result stalls the parse step only while out_tready is low; in_tready then
// drops once the input register is full.
// rst_n is synchronous; it clears the parse state and reloads the reset tag codes.
module tagged_pair_stream_parser_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tpsp_pkg::BYTE_W-1:0]         in_tdata,   // [7:0] in_byte
  input  logic                                in_tlast,   // op: end of stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [1:0] key_kind, [65:2] key_data, [67:66] value_kind, [131:68] value_data,
  // [135:132] zero
  output logic [tpsp_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [tpsp_pkg::RKIND_W-1:0]        out_tuser,  // [2:0] result_kind
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tpsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpsp_pkg::BYTE_W-1:0]         cfg_data
);

  // Configuration registers.
  logic [tpsp_pkg::BYTE_W-1:0] code_u8_r, code_u16_r, code_u32_r, code_u64_r, version_r;

  // Input register.
  logic                        s1_valid_r;
  logic                        s1_last_r;
  logic [tpsp_pkg::BYTE_W-1:0] s1_byte_r;
  logic                        s1_go;

  // Parse state.
  tpsp_pkg::phase_t              phase_r, phase_nxt;
  logic [tpsp_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [tpsp_pkg::KIND_W-1:0]   key_kind_r, key_kind_nxt;
  logic [tpsp_pkg::DATA_W-1:0]   key_r, key_nxt;
  logic [tpsp_pkg::KIND_W-1:0]   val_kind_r, val_kind_nxt;
  logic [tpsp_pkg::DATA_W-1:0]   val_r, val_nxt;

  // Result register.
  logic                          out_valid_r, out_valid_nxt;
  tpsp_pkg::result_kind_t        out_kind_r, emit_kind;
  logic [tpsp_pkg::KIND_W-1:0]   out_key_kind_r, out_val_kind_r;
  logic [tpsp_pkg::DATA_W-1:0]   out_key_r, out_val_r, emit_val;
  logic                          emit;

  logic                          tag_known;
  logic [tpsp_pkg::KIND_W-1:0]   tag_kind;
  logic [tpsp_pkg::CNT_W-1:0]    cnt_inc;

  assign cfg_ready = 1'b1;
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_u8_r  <= 8'd0;
      code_u16_r <= 8'd1;
      code_u32_r <= 8'd2;
      code_u64_r <= 8'd3;
      version_r  <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpsp_pkg::CFG_CODE_U8:  code_u8_r  <= cfg_data;
        tpsp_pkg::CFG_CODE_U16: code_u16_r <= cfg_data;
        tpsp_pkg::CFG_CODE_U32: code_u32_r <= cfg_data;
        tpsp_pkg::CFG_CODE_U64: code_u64_r <= cfg_data;
        tpsp_pkg::CFG_VERSION:  version_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_last_r <= in_tlast;
      s1_byte_r <= in_tdata;
    end
  end

  // Shared tag codes resolve to the narrowest kind.
  always_comb begin
    tag_known = 1'b1;
    tag_kind  = 2'd0;
    priority if (s1_byte_r == code_u8_r)  tag_kind = 2'd0;
    else if (s1_byte_r == code_u16_r)     tag_kind = 2'd1;
    else if (s1_byte_r == code_u32_r)     tag_kind = 2'd2;
    else if (s1_byte_r == code_u64_r)     tag_kind = 2'd3;
    else                                  tag_known = 1'b0;
  end

  assign cnt_inc = cnt_r + tpsp_pkg::CNT_W'(1);

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    key_kind_nxt = key_kind_r;
    key_nxt      = key_r;
    val_kind_nxt = val_kind_r;
    val_nxt      = val_r;
    emit         = 1'b0;
    emit_kind    = tpsp_pkg::RK_PAIR;
    emit_val     = '0;
    if (s1_go) begin
      if (s1_last_r) begin
        phase_nxt    = tpsp_pkg::PH_MAGIC;
        cnt_nxt      = '0;
        key_kind_nxt = '0;
        key_nxt      = '0;
        val_kind_nxt = '0;
        val_nxt      = '0;
        unique case (phase_r)
          tpsp_pkg::PH_KEY_TAG: begin
            emit      = 1'b1;
            emit_kind = tpsp_pkg::RK_END;
          end
          tpsp_pkg::PH_MAGIC, tpsp_pkg::PH_VERSION, tpsp_pkg::PH_KEY_BYTES,
          tpsp_pkg::PH_VAL_TAG, tpsp_pkg::PH_VAL_BYTES: begin
            emit      = 1'b1;
            emit_kind = tpsp_pkg::RK_TRUNCATED;
          end
          default: ;
        endcase
      end else begin
        unique case (phase_r)
          tpsp_pkg::PH_MAGIC: begin
            if (s1_byte_r != tpsp_pkg::magic_byte(cnt_r[1:0])) begin
              phase_nxt = tpsp_pkg::PH_ERROR;
              emit      = 1'b1;
              emit_kind = tpsp_pkg::RK_BAD_MAGIC;
            end else if (cnt_inc >= tpsp_pkg::CNT_W'(4)) begin
              cnt_nxt   = '0;
              phase_nxt = tpsp_pkg::PH_VERSION;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          tpsp_pkg::PH_VERSION: begin
            if (s1_byte_r != version_r) begin
              phase_nxt = tpsp_pkg::PH_ERROR;
              emit      = 1'b1;
              emit_kind = tpsp_pkg::RK_BAD_VERSION;
            end else begin
              phase_nxt = tpsp_pkg::PH_KEY_TAG;
            end
          end
          tpsp_pkg::PH_KEY_TAG, tpsp_pkg::PH_VAL_TAG: begin
            if (!tag_known) begin
              phase_nxt = tpsp_pkg::PH_ERROR;
              emit      = 1'b1;
              emit_kind = tpsp_pkg::RK_BAD_TAG;
            end else begin
              cnt_nxt = '0;
              if (phase_r == tpsp_pkg::PH_KEY_TAG) begin
                key_kind_nxt = tag_kind;
                key_nxt      = '0;
                phase_nxt    = tpsp_pkg::PH_KEY_BYTES;
              end else begin
                val_kind_nxt = tag_kind;
                val_nxt      = '0;
                phase_nxt    = tpsp_pkg::PH_VAL_BYTES;
              end
            end
          end
          tpsp_pkg::PH_KEY_BYTES: begin
            key_nxt = {key_r[tpsp_pkg::DATA_W-tpsp_pkg::BYTE_W-1:0], s1_byte_r};
            if (cnt_inc >= tpsp_pkg::kind_len(key_kind_r)) begin
              cnt_nxt   = '0;
              phase_nxt = tpsp_pkg::PH_VAL_TAG;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          tpsp_pkg::PH_VAL_BYTES: begin
            emit_val = {val_r[tpsp_pkg::DATA_W-tpsp_pkg::BYTE_W-1:0], s1_byte_r};
            if (cnt_inc >= tpsp_pkg::kind_len(val_kind_r)) begin
              emit         = 1'b1;
              emit_kind    = tpsp_pkg::RK_PAIR;
              cnt_nxt      = '0;
              key_nxt      = '0;
              val_nxt      = '0;
              key_kind_nxt = '0;
              val_kind_nxt = '0;
              phase_nxt    = tpsp_pkg::PH_KEY_TAG;
            end else begin
              val_nxt = emit_val;
              cnt_nxt = cnt_inc;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= tpsp_pkg::PH_MAGIC;
      cnt_r      <= '0;
      key_kind_r <= '0;
      key_r      <= '0;
      val_kind_r <= '0;
      val_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      key_kind_r <= key_kind_nxt;
      key_r      <= key_nxt;
      val_kind_r <= val_kind_nxt;
      val_r      <= val_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Only pair results carry key and value; every other kind shows zeros.
  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      out_kind_r <= emit_kind;
      if (emit_kind == tpsp_pkg::RK_PAIR) begin
        out_key_kind_r <= key_kind_r;
        out_key_r      <= key_r;
        out_val_kind_r <= val_kind_r;
        out_val_r      <= emit_val;
      end else begin
        out_key_kind_r <= '0;
        out_key_r      <= '0;
        out_val_kind_r <= '0;
        out_val_r      <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {4'd0, out_val_r, out_val_kind_r, out_key_r, out_key_kind_r};

  a_nonpair_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != tpsp_pkg::RK_PAIR) |-> (out_tdata == '0))
    else $error("non-pair result carries key or value bits");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last_r) |=> (phase_r == tpsp_pkg::PH_MAGIC && cnt_r == '0))
    else $error("end of stream did not return the parser to the header");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= tpsp_pkg::CNT_W'(8)))
    else $error("byte count beyond the widest item");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && emit) |=> out_tvalid)
    else $error("result found but not presented");

endmodule

[sim/testbench.sv]
// Self-checking testbench of the tagged pair stream parser: random streams against a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tpsp_pkg::*;

  localparam logic [31:0] HEADER_MAGIC = 32'h4B56_5300;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef enum logic [KIND_W-1:0] {W_U8, W_U16, W_U32, W_U64} width_code_t;

  typedef struct packed {
    result_kind_t            kind;
    logic [KIND_W-1:0]       key_kind;
    logic [DATA_W-1:0]       key_data;
    logic [KIND_W-1:0]       value_kind;
    logic [DATA_W-1:0]       value_data;
  } parse_result_t;

  typedef struct {
    logic              last;
    logic [BYTE_W-1:0] data;
    int unsigned       gap;
  } stream_item_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [RKIND_W-1:0]    out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [BYTE_W-1:0]     cfg_data = '0;

  // Predictor copy of the registers and the parse state.
  logic [BYTE_W-1:0] tag_code [4];
  logic [BYTE_W-1:0] want_version;
  phase_t            parse_phase = PH_MAGIC;
  logic [CNT_W-1:0]  taken_count = '0;
  width_code_t       held_key_kind = W_U8;
  logic [DATA_W-1:0] held_key = '0;
  width_code_t       held_value_kind = W_U8;
  logic [DATA_W-1:0] value_shift = '0;

  parse_result_t pending_results [$];
  stream_item_t  stream_items [$];
  stream_item_t  next_item;

  int unsigned items_sent = 0;
  int unsigned items_taken = 0;
  int unsigned gap_waited = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_stall = 0;
  int unsigned hold_left = 0;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          gap_style = 1;
  int          rx_style = 1;
  logic        burst_only = 1'b0;

  tagged_pair_stream_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Style 0 never waits, style 1 waits evenly, style 2 waits now and then.
  function automatic int unsigned draw_wait(input int style);
    int unsigned n;
    case (style)
      0: n = 0;
      1: n = $urandom_range(0, 13);
      default: n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
    endcase
    return n;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] wanted);
    $display("%0t: %s mismatch, got %0h, wanted %0h", $time, what, got, wanted);
    mismatch_count++;
  endtask

  task automatic clear_parse(input phase_t next_phase);
    parse_phase = next_phase;
    taken_count = '0;
    held_key_kind = W_U8;
    held_key = '0;
    held_value_kind = W_U8;
    value_shift = '0;
  endtask

  // Advances the predicted parser by one accepted item and queues any result it gives.
  task automatic parse_stream_item(input logic last, input logic [BYTE_W-1:0] data);
    parse_result_t r;
    width_code_t   w;
    logic          hit;
    r = '0;
    w = W_U8;
    if (last) begin
      if (parse_phase == PH_KEY_TAG) begin
        r.kind = RK_END;
        pending_results.push_back(r);
      end else if (parse_phase <= PH_VAL_BYTES) begin
        r.kind = RK_TRUNCATED;
        pending_results.push_back(r);
      end
      clear_parse(PH_MAGIC);
    end else begin
      case (parse_phase)
        PH_MAGIC: begin
          if (data != HEADER_MAGIC[31 - 8 * taken_count[1:0] -: 8]) begin
            r.kind = RK_BAD_MAGIC;
            pending_results.push_back(r);
            parse_phase = PH_ERROR;
          end else if (taken_count == 4'd3) begin
            taken_count = '0;
            parse_phase = PH_VERSION;
          end else begin
            taken_count = taken_count + 4'd1;
          end
        end
        PH_VERSION: begin
          if (data != want_version) begin
            r.kind = RK_BAD_VERSION;
            pending_results.push_back(r);
            parse_phase = PH_ERROR;
          end else begin
            parse_phase = PH_KEY_TAG;
          end
        end
        PH_KEY_TAG, PH_VAL_TAG: begin
          // When codes are shared, the narrowest width takes the tag.
          hit = 1'b1;
          if (data == tag_code[W_U8]) w = W_U8;
          else if (data == tag_code[W_U16]) w = W_U16;
          else if (data == tag_code[W_U32]) w = W_U32;
          else if (data == tag_code[W_U64]) w = W_U64;
          else hit = 1'b0;
          taken_count = '0;
          if (!hit) begin
            r.kind = RK_BAD_TAG;
            pending_results.push_back(r);
            parse_phase = PH_ERROR;
          end else if (parse_phase == PH_KEY_TAG) begin
            held_key_kind = w;
            held_key = '0;
            parse_phase = PH_KEY_BYTES;
          end else begin
            held_value_kind = w;
            value_shift = '0;
            parse_phase = PH_VAL_BYTES;
          end
        end
        PH_KEY_BYTES: begin
          held_key = {held_key[DATA_W-BYTE_W-1:0], data};
          taken_count = taken_count + 4'd1;
          if (taken_count == (4'd1 << held_key_kind)) begin
            taken_count = '0;
            parse_phase = PH_VAL_TAG;
          end
        end
        PH_VAL_BYTES: begin
          value_shift = {value_shift[DATA_W-BYTE_W-1:0], data};
          taken_count = taken_count + 4'd1;
          if (taken_count == (4'd1 << held_value_kind)) begin
            r.kind = RK_PAIR;
            r.key_kind = held_key_kind;
            r.key_data = held_key;
            r.value_kind = held_value_kind;
            r.value_data = value_shift;
            pending_results.push_back(r);
            clear_parse(PH_KEY_TAG);
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_result();
    parse_result_t wanted;
    if (pending_results.size() == 0) begin
      flag_mismatch("unexpected result", 64'(out_tuser), 64'd0);
    end else begin
      wanted = pending_results.pop_front();
      if (out_tuser !== wanted.kind)
        flag_mismatch("result_kind", 64'(out_tuser), 64'(wanted.kind));
      if (out_tdata[1:0] !== wanted.key_kind)
        flag_mismatch("key_kind", 64'(out_tdata[1:0]), 64'(wanted.key_kind));
      if (out_tdata[65:2] !== wanted.key_data)
        flag_mismatch("key_data", out_tdata[65:2], wanted.key_data);
      if (out_tdata[67:66] !== wanted.value_kind)
        flag_mismatch("value_kind", 64'(out_tdata[67:66]), 64'(wanted.value_kind));
      if (out_tdata[131:68] !== wanted.value_data)
        flag_mismatch("value_data", out_tdata[131:68], wanted.value_data);
    end
  endtask

  task automatic push_item(input logic last, input logic [BYTE_W-1:0] data);
    stream_item_t it;
    it.last = last;
    it.data = data;
    it.gap = draw_wait(gap_style);
    stream_items.push_back(it);
    items_sent++;
  endtask

  // One stream: header, a few pairs and an end item, now and then damaged on purpose.
  task automatic gen_stream();
    logic [BYTE_W-1:0] body [$];
    int                tag_at [$];
    int                pairs;
    int                twist;
    int                pos;
    width_code_t       w;
    logic [DATA_W-1:0] v;
    logic [BYTE_W-1:0] odd_tag;
    gap_style = burst_only ? 0 : $urandom_range(0, 2);
    for (int i = 0; i < 4; i++) body.push_back(HEADER_MAGIC[31 - 8 * i -: 8]);
    body.push_back(want_version);
    pairs = $urandom_range(0, 5);
    repeat (2 * pairs) begin
      // Mostly narrow items keep the streams short.
      case ($urandom_range(0, 9))
        0, 1, 2, 3: w = W_U8;
        4, 5, 6:    w = W_U16;
        7, 8:       w = W_U32;
        default:    w = W_U64;
      endcase
      case ($urandom_range(0, 5))
        0:       v = '0;
        1:       v = '1;
        default: v = {$urandom, $urandom};
      endcase
      tag_at.push_back(body.size());
      body.push_back(tag_code[w]);
      for (int i = (1 << w) - 1; i >= 0; i--) body.push_back(v[8 * i +: 8]);
    end
    twist = $urandom_range(0, 19);
    case (twist)
      13: begin
        pos = $urandom_range(0, body.size() - 1);
        while (body.size() > pos) void'(body.pop_back());
      end
      14: begin
        pos = $urandom_range(0, 3);
        body[pos] = body[pos] ^ 8'($urandom_range(1, 255));
      end
      15: body[4] = body[4] ^ 8'($urandom_range(1, 255));
      16: begin
        if (tag_at.size() > 0) begin
          do odd_tag = 8'($urandom);
          while (odd_tag == tag_code[0] || odd_tag == tag_code[1] ||
                 odd_tag == tag_code[2] || odd_tag == tag_code[3]);
          body[tag_at[$urandom_range(0, tag_at.size() - 1)]] = odd_tag;
        end
      end
      17: begin
        pos = $urandom_range(0, body.size() - 1);
        body[pos] = 8'($urandom);
      end
      18: begin
        body.delete();
        repeat ($urandom_range(0, 10)) body.push_back(8'($urandom));
      end
      default: ;
    endcase
    foreach (body[i]) push_item(1'b0, body[i]);
    push_item(1'b1, 8'($urandom));
    // An extra end item right after is an empty stream.
    if (twist == 19) push_item(1'b1, 8'($urandom));
  endtask

  task automatic run_streams(input int unsigned count);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < count) gen_stream();
  endtask

  // Waits until every item is in and every predicted result is out, then lets the pipe empty.
  task automatic drain();
    while (items_taken != items_sent || pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [BYTE_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CODE_U8:  tag_code[W_U8] = val;
      CFG_CODE_U16: tag_code[W_U16] = val;
      CFG_CODE_U32: tag_code[W_U32] = val;
      CFG_CODE_U64: tag_code[W_U64] = val;
      CFG_VERSION:  want_version = val;
      default: ;
    endcase
  endtask

  task automatic program_codes(input logic [BYTE_W-1:0] c8, input logic [BYTE_W-1:0] c16,
                               input logic [BYTE_W-1:0] c32, input logic [BYTE_W-1:0] c64,
                               input logic [BYTE_W-1:0] ver);
    write_reg(CFG_CODE_U8, c8);
    write_reg(CFG_CODE_U16, c16);
    write_reg(CFG_CODE_U32, c32);
    write_reg(CFG_CODE_U64, c64);
    write_reg(CFG_VERSION, ver);
  endtask

  // Input side: each item waits out its own gap, then is offered until taken.
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      parse_stream_item(in_tlast, in_tdata);
      items_taken++;
    end
    if (!in_tvalid || in_tready) begin
      if (rst_n && stream_items.size() > 0 && gap_waited < stream_items[0].gap) begin
        gap_waited++;
        in_tvalid <= 1'b0;
      end else if (rst_n && stream_items.size() > 0) begin
        next_item = stream_items.pop_front();
        gap_waited = 0;
        in_tvalid <= 1'b1;
        in_tdata <= next_item.data;
        in_tlast <= next_item.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side: checks each result and may stall before taking the next one.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      check_result();
      rx_stall = draw_wait(rx_style);
    end
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    tag_code[W_U8] = 8'd0;
    tag_code[W_U16] = 8'd1;
    tag_code[W_U32] = 8'd2;
    tag_code[W_U64] = 8'd3;
    want_version = 8'd1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed streams with the reset codes.
    gap_style = 1;
    rx_style = 1;
    push_item(1'b1, 8'hA5);                      // empty stream
    push_item(1'b0, 8'h00);                      // wrong first magic byte
    push_item(1'b1, 8'h00);                      // end after an error is silent
    for (int i = 0; i < 4; i++) push_item(1'b0, HEADER_MAGIC[31 - 8 * i -: 8]);
    push_item(1'b0, 8'h00);                      // wrong version
    push_item(1'b0, 8'h55);                      // ignored after the error
    push_item(1'b1, 8'hFF);
    for (int i = 0; i < 4; i++) push_item(1'b0, HEADER_MAGIC[31 - 8 * i -: 8]);
    push_item(1'b0, 8'h01);
    push_item(1'b0, 8'h00);                      // u8 key 0xFF
    push_item(1'b0, 8'hFF);
    push_item(1'b0, 8'h03);                      // u64 value of all ones
    repeat (8) push_item(1'b0, 8'hFF);
    push_item(1'b1, 8'h00);                      // end at a pair boundary
    run_streams(150);
    drain();

    program_codes(8'hFF, 8'h00, 8'h7F, 8'h80, 8'hFF);
    rx_style = 2;
    // The receiver holds off while a burst of streams keeps the input busy.
    burst_only = 1'b1;
    hold_requests++;
    run_streams(80);
    burst_only = 1'b0;
    drain();
    run_streams(70);
    drain();

    // Every tag code shared: all tags decode as one-byte items.
    program_codes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    rx_style = 0;
    run_streams(150);
    drain();

    program_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    rx_style = 1;
    run_streams(150);
    drain();

    program_codes(8'h4B, 8'h56, 8'h4B, 8'hFF, 8'h4B);
    rx_style = 2;
    run_streams(150);
    drain();

    program_codes(8'($urandom), 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                  8'($urandom), 8'($urandom));
    rx_style = 1;
    run_streams(150);
    drain();
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/tpsp_pkg.sv
hw/rtl/tagged_pair_stream_parser_core.sv
sim/testbench.sv
